/* sv/legged_motion_mode_governor_macros.svh */
// Assertion macros shared by the motion mode governor modules.
`ifndef LEGGED_MOTION_MODE_GOVERNOR_MACROS_SVH
`define LEGGED_MOTION_MODE_GOVERNOR_MACROS_SVH

`ifndef SYNTHESIS
`define LMMG_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	prop) else $error("motion mode governor assertion failed");
`define LMMG_ASSERT_ALWAYS(lbl, prop) lbl: assert property (@(posedge clk) prop) \
	else $error("motion mode governor invariant violated");
`else
`define LMMG_ASSERT(lbl, prop)
`define LMMG_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

/* sv/lmmg_pkg.sv */
// Shared types, codes and helpers for the motion mode governor.
package lmmg_pkg;

	localparam int WALK_GAIT = 1;

	localparam logic [17:0] ELAPSED_MAX = 18'h3FFFF;
	localparam logic [16:0] AGE_MAX     = 17'h1FFFF;

	localparam logic [1:0] REQ_TICK = 2'd0;
	localparam logic [1:0] REQ_VEL  = 2'd1;
	localparam logic [1:0] REQ_MODE = 2'd2;
	localparam logic [1:0] REQ_NONE = 2'd3;

	localparam logic [2:0] MCODE_AUTO    = 3'd0;
	localparam logic [2:0] MCODE_INVALID = 3'd7;

	localparam logic [2:0] CFG_TIMEOUT = 3'd0;
	localparam logic [2:0] CFG_LIM_VX  = 3'd1;
	localparam logic [2:0] CFG_LIM_VY  = 3'd2;
	localparam logic [2:0] CFG_LIM_WZ  = 3'd3;
	localparam logic [2:0] CFG_LIE     = 3'd4;
	localparam logic [2:0] CFG_RECOVER = 3'd5;
	localparam logic [2:0] CFG_RISE    = 3'd6;
	localparam logic [2:0] CFG_HOLD    = 3'd7;

	localparam logic [2:0] GAIT_IDLE = 3'd0;
	localparam logic [2:0] WALK_GAIT_CODE =
		(WALK_GAIT >= 2 && WALK_GAIT <= 4) ? 3'(WALK_GAIT) : 3'd1;

	typedef enum logic [2:0] {
		MODE_IDLE        = 3'd0,
		MODE_FORCE_STAND = 3'd1,
		MODE_WALK        = 3'd2,
		MODE_STAND_DOWN  = 3'd3,
		MODE_STAND_UP    = 3'd4,
		MODE_RECOVERY    = 3'd5
	} drive_mode_t;

	typedef struct packed {
		logic [15:0] timeout_ticks;
		logic [14:0] limit_vx;
		logic [14:0] limit_vy;
		logic [14:0] limit_wz;
		logic [17:0] edge_down;
		logic [17:0] edge_recover;
		logic [17:0] edge_rise;
		logic [17:0] edge_hold;
	} cfg_t;

	typedef struct packed {
		drive_mode_t        mode;
		logic [2:0]         gait;
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic signed [15:0] wz;
	} res_t;

	function automatic logic signed [15:0] clamp_sym(logic signed [15:0] v, logic [14:0] lim);
		logic signed [15:0] l;
		l = $signed({1'b0, lim});
		if (v > l) begin
			return l;
		end else if (v < -l) begin
			return -l;
		end
		return v;
	endfunction

endpackage

/* sv/lmmg_cfg.sv */
// Configuration registers and precomputed startup phase boundaries.
module lmmg_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [2:0]    wr_index,
	input  logic [15:0]   wr_data,
	output lmmg_pkg::cfg_t cfg
);
	import lmmg_pkg::*;

	logic [15:0] timeout_q;
	logic [14:0] lim_vx_q;
	logic [14:0] lim_vy_q;
	logic [14:0] lim_wz_q;
	logic [15:0] lie_q;
	logic [15:0] recover_q;
	logic [15:0] rise_q;
	logic [15:0] hold_q;
	logic [17:0] edge_down_q;
	logic [17:0] edge_recover_q;
	logic [17:0] edge_rise_q;
	logic [17:0] edge_hold_q;
	logic [17:0] sum_lr;
	logic [17:0] sum_uh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= 16'd175;
			lim_vx_q  <= 15'd350;
			lim_vy_q  <= 15'd250;
			lim_wz_q  <= 15'd800;
			lie_q     <= 16'd1000;
			recover_q <= 16'd1000;
			rise_q    <= 16'd500;
			hold_q    <= 16'd500;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_TIMEOUT: timeout_q <= wr_data;
				CFG_LIM_VX:  lim_vx_q  <= wr_data[14:0];
				CFG_LIM_VY:  lim_vy_q  <= wr_data[14:0];
				CFG_LIM_WZ:  lim_wz_q  <= wr_data[14:0];
				CFG_LIE:     lie_q     <= wr_data;
				CFG_RECOVER: recover_q <= wr_data;
				CFG_RISE:    rise_q    <= wr_data;
				CFG_HOLD:    hold_q    <= wr_data;
			endcase
		end
	end

	assign sum_lr = {2'b00, lie_q} + {2'b00, recover_q};
	assign sum_uh = {2'b00, rise_q} + {2'b00, hold_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_down_q    <= 18'd1000;
			edge_recover_q <= 18'd2000;
			edge_rise_q    <= 18'd2500;
			edge_hold_q    <= 18'd3000;
		end else begin
			edge_down_q    <= {2'b00, lie_q};
			edge_recover_q <= sum_lr;
			edge_rise_q    <= sum_lr + {2'b00, rise_q};
			edge_hold_q    <= sum_lr + sum_uh;
		end
	end

	assign cfg.timeout_ticks = timeout_q;
	assign cfg.limit_vx      = lim_vx_q;
	assign cfg.limit_vy      = lim_vy_q;
	assign cfg.limit_wz      = lim_wz_q;
	assign cfg.edge_down     = edge_down_q;
	assign cfg.edge_recover  = edge_recover_q;
	assign cfg.edge_rise     = edge_rise_q;
	assign cfg.edge_hold     = edge_hold_q;

endmodule

/* sv/lmmg_core.sv */
// Governor state, mode selection and velocity clamping for one item.
`include "legged_motion_mode_governor_macros.svh"

module lmmg_core (
	input  logic               clk,
	input  logic               arst_n,
	input  lmmg_pkg::cfg_t     cfg,
	input  logic               fire,
	input  logic [1:0]         req_type,
	input  logic [2:0]         mode_code,
	input  logic signed [15:0] vel_x,
	input  logic signed [15:0] vel_y,
	input  logic signed [15:0] yaw_rate,
	output lmmg_pkg::res_t     res
);
	import lmmg_pkg::*;

	logic               override_q;
	logic               startup_q;
	drive_mode_t        held_mode_q;
	logic [17:0]        elapsed_q;
	logic               cmd_valid_q;
	logic [16:0]        cmd_age_q;
	logic signed [15:0] held_vx_q;
	logic signed [15:0] held_vy_q;
	logic signed [15:0] held_wz_q;
	drive_mode_t        mode_sel;
	logic               fresh;
	logic               vel_moving;

	always_comb begin
		priority if (override_q) begin
			mode_sel = held_mode_q;
		end else if (!startup_q) begin
			mode_sel = MODE_WALK;
		end else if (elapsed_q < cfg.edge_down) begin
			mode_sel = MODE_STAND_DOWN;
		end else if (elapsed_q < cfg.edge_recover) begin
			mode_sel = MODE_RECOVERY;
		end else if (elapsed_q < cfg.edge_rise) begin
			mode_sel = MODE_STAND_UP;
		end else if (elapsed_q < cfg.edge_hold) begin
			mode_sel = MODE_FORCE_STAND;
		end else begin
			mode_sel = MODE_WALK;
		end
	end

	assign fresh = cmd_valid_q && (cmd_age_q <= {1'b0, cfg.timeout_ticks});

	always_comb begin
		res.mode = mode_sel;
		res.gait = GAIT_IDLE;
		res.vx   = '0;
		res.vy   = '0;
		res.wz   = '0;
		if (mode_sel == MODE_WALK) begin
			res.gait = WALK_GAIT_CODE;
			if (fresh) begin
				res.vx = clamp_sym(held_vx_q, cfg.limit_vx);
				res.vy = clamp_sym(held_vy_q, cfg.limit_vy);
				res.wz = clamp_sym(held_wz_q, cfg.limit_wz);
			end
		end
	end

	assign vel_moving = (res.vx != '0) || (res.vy != '0) || (res.wz != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			override_q  <= 1'b0;
			startup_q   <= 1'b1;
			held_mode_q <= MODE_WALK;
			elapsed_q   <= '0;
			cmd_valid_q <= 1'b0;
			cmd_age_q   <= '0;
			held_vx_q   <= '0;
			held_vy_q   <= '0;
			held_wz_q   <= '0;
		end else if (fire) begin
			unique case (req_type)
				REQ_VEL: begin
					held_vx_q   <= vel_x;
					held_vy_q   <= vel_y;
					held_wz_q   <= yaw_rate;
					cmd_valid_q <= 1'b1;
					cmd_age_q   <= '0;
				end
				REQ_MODE: begin
					priority if (mode_code == MCODE_AUTO) begin
						startup_q   <= 1'b1;
						override_q  <= 1'b0;
						elapsed_q   <= '0;
						held_vx_q   <= '0;
						held_vy_q   <= '0;
						held_wz_q   <= '0;
						cmd_valid_q <= 1'b0;
						cmd_age_q   <= '0;
					end else if (mode_code != MCODE_INVALID) begin
						startup_q   <= 1'b0;
						override_q  <= 1'b1;
						held_mode_q <= drive_mode_t'(mode_code - 3'd1);
						if (drive_mode_t'(mode_code - 3'd1) != MODE_WALK) begin
							held_vx_q   <= '0;
							held_vy_q   <= '0;
							held_wz_q   <= '0;
							cmd_valid_q <= 1'b0;
							cmd_age_q   <= '0;
						end
					end else begin
					end
				end
				REQ_TICK: begin
					if (elapsed_q != ELAPSED_MAX) begin
						elapsed_q <= elapsed_q + 18'd1;
					end
					if (cmd_age_q != AGE_MAX) begin
						cmd_age_q <= cmd_age_q + 17'd1;
					end
				end
				REQ_NONE: begin
				end
			endcase
		end
	end

	`LMMG_ASSERT_ALWAYS(a_override_excl, !(override_q && startup_q))
	`LMMG_ASSERT(a_vel_store, (fire && req_type == REQ_VEL) |=> (cmd_valid_q && cmd_age_q == '0))
	`LMMG_ASSERT(a_vel_walk, vel_moving |-> (res.mode == MODE_WALK && res.gait == WALK_GAIT_CODE))

endmodule

/* sv/legged_motion_mode_governor.sv */
// Top level of the legged robot motion mode governor.
//
//  Channel   | Direction | Contents
//  s_axis    | in        | tuser: req_type; tdata: mode_code, vel_x, vel_y, yaw_rate
//  m_axis    | out       | tdata: drive_mode, gait, out_vx, out_vy, out_wz (ticks only)
//  cfg       | in        | cfg_index selects one of eight registers, cfg_data is the value
//
// One transaction is accepted per cycle while no tick waits in the input register; a tick's
// result is registered in the result register. The rate is set by the single pass from the
// input register through the state update into the result register. A tick waits in the input
// register while the result register is full and not taken; other transactions pass. Reset
// restores the register defaults and the startup sequence. cfg_ready is always high.
`include "legged_motion_mode_governor_macros.svh"

module legged_motion_mode_governor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // mode_code, vel_x, vel_y, yaw_rate, zero fill
	input  logic [1:0]  s_axis_tuser,  // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,  // drive_mode, gait, out_vx, out_vy, out_wz, zero fill
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import lmmg_pkg::*;

	cfg_t               cfg;
	res_t               res;
	res_t               res_q;
	logic               in_valid_s1;
	logic [1:0]         req_s1;
	logic [2:0]         code_s1;
	logic signed [15:0] vx_s1;
	logic signed [15:0] vy_s1;
	logic signed [15:0] wz_s1;
	logic               out_valid_q;
	logic               is_tick;
	logic               out_free;
	logic               proc;

	assign cfg_ready = 1'b1;

	lmmg_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign is_tick       = (req_s1 == REQ_TICK);
	assign out_free      = !out_valid_q || m_axis_tready;
	assign proc          = in_valid_s1 && (!is_tick || out_free);
	assign s_axis_tready = !in_valid_s1 || proc;

	lmmg_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.fire      (proc),
		.req_type  (req_s1),
		.mode_code (code_s1),
		.vel_x     (vx_s1),
		.vel_y     (vy_s1),
		.yaw_rate  (wz_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				in_valid_s1 <= s_axis_tvalid;
			end
			if (proc && is_tick) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			req_s1  <= s_axis_tuser;
			code_s1 <= s_axis_tdata[2:0];
			vx_s1   <= s_axis_tdata[18:3];
			vy_s1   <= s_axis_tdata[34:19];
			wz_s1   <= s_axis_tdata[50:35];
		end
		if (proc && is_tick) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, res_q.wz, res_q.vy, res_q.vx, res_q.gait, res_q.mode};

	`LMMG_ASSERT(a_tick_result, (proc && is_tick) |=> out_valid_q)
	`LMMG_ASSERT(a_tick_waits, (in_valid_s1 && is_tick && !out_free) |=> (in_valid_s1 && $stable(req_s1)))
	`LMMG_ASSERT(a_other_flows, (in_valid_s1 && !is_tick) |-> s_axis_tready)

endmodule
